// ===== rtl/ghi_pkg.sv =====
// Shared types, widths and constants of the gyro heading integrator.
package ghi_pkg;

  localparam int RAW_W   = 16;
  localparam int TIME_W  = 32;
  localparam int SET_W   = 27;
  localparam int HEAD_W  = 27;
  localparam int HOUT_W  = 26;
  localparam int RATE_W  = 25;
  localparam int BIAS_W  = 24;
  localparam int GAIN_W  = 24;
  localparam int MAX_W   = 25;
  localparam int MIN_W   = 26;
  localparam int TURN_W  = 26;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 4;
  localparam int RFRAC_W = 8;
  localparam int MOP_W   = 25;
  localparam int MPROD_W = 2 * MOP_W;
  localparam int P_W     = 44;
  localparam int PLO_W   = 22;
  localparam int PG_W    = 46;
  localparam int D_SHIFT = 40 - PLO_W;
  localparam int HW_W    = 30;

  localparam logic [GAIN_W-1:0]        GAIN_RST = GAIN_W'(2148664);
  localparam logic [MAX_W-1:0]         HMAX_RST = MAX_W'(11796480);
  localparam logic signed [MIN_W-1:0]  HMIN_RST = -MIN_W'(11796480);
  localparam logic [TURN_W-1:0]        TURN_RST = TURN_W'(23592960);

  typedef enum logic [1:0] {
    CMD_CAL    = 2'd0,
    CMD_UPDATE = 2'd1,
    CMD_RESET  = 2'd2,
    CMD_SET    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REG_GAIN = 2'd0,
    REG_HMAX = 2'd1,
    REG_HMIN = 2'd2,
    REG_TURN = 2'd3
  } reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MUL_P,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_SUM,
    ST_ACC,
    ST_WRAP_HI,
    ST_WRAP_LO,
    ST_CLAMP,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic [GAIN_W-1:0]       gain;
    logic [MAX_W-1:0]        hmax;
    logic signed [MIN_W-1:0] hmin;
    logic [TURN_W-1:0]       turn;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic cal_step;
    logic rst_head;
    logic set_load;
    logic upd_start;
    logic ld_p;
    logic ld_lo;
    logic ld_hi;
    logic ld_delta;
    logic ld_acc;
    logic wrap_hi;
    logic wrap_lo;
    logic clamp;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    cmd_e cmd;
    logic calibrated;
  } dp_sts_t;

endpackage

// ===== rtl/ghi_regs.sv =====
// APB configuration registers of the gyro heading integrator.
module ghi_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ghi_pkg::ADDR_W-1:0]   paddr,
  input  logic [ghi_pkg::DATA_W-1:0]   pwdata,
  output logic [ghi_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output ghi_pkg::cfg_t                cfg_o
);

  ghi_pkg::cfg_t cfg_q;
  ghi_pkg::cfg_t cfg_d;
  ghi_pkg::reg_e sel;
  logic          wr_en;

  assign sel    = ghi_pkg::reg_e'(paddr[ghi_pkg::ADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (sel)
        ghi_pkg::REG_GAIN: cfg_d.gain = pwdata[ghi_pkg::GAIN_W-1:0];
        ghi_pkg::REG_HMAX: cfg_d.hmax = pwdata[ghi_pkg::MAX_W-1:0];
        ghi_pkg::REG_HMIN: cfg_d.hmin = $signed(pwdata[ghi_pkg::MIN_W-1:0]);
        ghi_pkg::REG_TURN: cfg_d.turn = pwdata[ghi_pkg::TURN_W-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      ghi_pkg::REG_GAIN:
        prdata = {{(ghi_pkg::DATA_W-ghi_pkg::GAIN_W){1'b0}}, cfg_q.gain};
      ghi_pkg::REG_HMAX:
        prdata = {{(ghi_pkg::DATA_W-ghi_pkg::MAX_W){1'b0}}, cfg_q.hmax};
      ghi_pkg::REG_HMIN:
        prdata = {{(ghi_pkg::DATA_W-ghi_pkg::MIN_W){cfg_q.hmin[ghi_pkg::MIN_W-1]}},
                  cfg_q.hmin};
      ghi_pkg::REG_TURN:
        prdata = {{(ghi_pkg::DATA_W-ghi_pkg::TURN_W){1'b0}}, cfg_q.turn};
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain <= ghi_pkg::GAIN_RST;
      cfg_q.hmax <= ghi_pkg::HMAX_RST;
      cfg_q.hmin <= ghi_pkg::HMIN_RST;
      cfg_q.turn <= ghi_pkg::TURN_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== rtl/ghi_ctrl.sv =====
// Sequencing state machine and output handshake of the gyro heading integrator.
module ghi_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  ghi_pkg::dp_sts_t sts_i,
  output ghi_pkg::dp_cmd_t dp_cmd_o
);

  ghi_pkg::state_e state_q;
  ghi_pkg::state_e state_d;
  logic            out_valid_q;
  logic            out_valid_d;
  logic            out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ghi_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ghi_pkg::ST_IDLE:    if (in_valid_i) state_d = ghi_pkg::ST_DECODE;
      ghi_pkg::ST_DECODE: begin
        unique case (sts_i.cmd)
          ghi_pkg::CMD_SET:    state_d = ghi_pkg::ST_WRAP_HI;
          ghi_pkg::CMD_UPDATE: state_d = sts_i.calibrated ? ghi_pkg::ST_MUL_P
                                                          : ghi_pkg::ST_FIN;
          default:             state_d = ghi_pkg::ST_FIN;
        endcase
      end
      ghi_pkg::ST_MUL_P:   state_d = ghi_pkg::ST_MUL_LO;
      ghi_pkg::ST_MUL_LO:  state_d = ghi_pkg::ST_MUL_HI;
      ghi_pkg::ST_MUL_HI:  state_d = ghi_pkg::ST_SUM;
      ghi_pkg::ST_SUM:     state_d = ghi_pkg::ST_ACC;
      ghi_pkg::ST_ACC:     state_d = ghi_pkg::ST_WRAP_HI;
      ghi_pkg::ST_WRAP_HI: state_d = ghi_pkg::ST_WRAP_LO;
      ghi_pkg::ST_WRAP_LO: state_d = ghi_pkg::ST_CLAMP;
      ghi_pkg::ST_CLAMP:   state_d = ghi_pkg::ST_FIN;
      ghi_pkg::ST_FIN:     if (out_free) state_d = ghi_pkg::ST_IDLE;
      default:             state_d = ghi_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    dp_cmd_o = '0;
    unique case (state_q)
      ghi_pkg::ST_IDLE:    dp_cmd_o.capture = in_valid_i;
      ghi_pkg::ST_DECODE: begin
        dp_cmd_o.cal_step  = (sts_i.cmd == ghi_pkg::CMD_CAL);
        dp_cmd_o.rst_head  = (sts_i.cmd == ghi_pkg::CMD_RESET);
        dp_cmd_o.set_load  = (sts_i.cmd == ghi_pkg::CMD_SET);
        dp_cmd_o.upd_start = (sts_i.cmd == ghi_pkg::CMD_UPDATE) && sts_i.calibrated;
      end
      ghi_pkg::ST_MUL_P:   dp_cmd_o.ld_p     = 1'b1;
      ghi_pkg::ST_MUL_LO:  dp_cmd_o.ld_lo    = 1'b1;
      ghi_pkg::ST_MUL_HI:  dp_cmd_o.ld_hi    = 1'b1;
      ghi_pkg::ST_SUM:     dp_cmd_o.ld_delta = 1'b1;
      ghi_pkg::ST_ACC:     dp_cmd_o.ld_acc   = 1'b1;
      ghi_pkg::ST_WRAP_HI: dp_cmd_o.wrap_hi  = 1'b1;
      ghi_pkg::ST_WRAP_LO: dp_cmd_o.wrap_lo  = 1'b1;
      ghi_pkg::ST_CLAMP:   dp_cmd_o.clamp    = 1'b1;
      ghi_pkg::ST_FIN:     dp_cmd_o.out_load = out_free;
      default:             dp_cmd_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (dp_cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ghi_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== rtl/ghi_dp.sv =====
// Datapath of the gyro heading integrator: calibration, shared multiplier, wrap.
module ghi_dp #(
  parameter int CAL_SAMPLES = 256,
  parameter int MAX_DT_US   = 500000
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ghi_pkg::dp_cmd_t                    dp_cmd_i,
  output ghi_pkg::dp_sts_t                    sts_o,
  input  ghi_pkg::cfg_t                       cfg_i,
  input  logic [1:0]                          cmd_i,
  input  logic signed [ghi_pkg::RAW_W-1:0]    raw_rate_i,
  input  logic [ghi_pkg::TIME_W-1:0]          now_us_i,
  input  logic signed [ghi_pkg::SET_W-1:0]    set_value_q16_i,
  output logic signed [ghi_pkg::HOUT_W-1:0]   heading_q16_o,
  output logic signed [ghi_pkg::RATE_W-1:0]   rate_q8_o,
  output logic signed [ghi_pkg::BIAS_W-1:0]   bias_q8_o,
  output logic                                is_calibrated_o
);

  localparam int CAL_LOG = $clog2(CAL_SAMPLES);
  localparam int CNT_W   = $clog2(CAL_SAMPLES + 1);
  localparam int SUM_W   = ghi_pkg::RAW_W + CAL_LOG;
  localparam int NUM_W   = SUM_W + ghi_pkg::RFRAC_W;
  localparam int DT_W    = $clog2(MAX_DT_US + 1);
  localparam int LOH_W   = ghi_pkg::PG_W - ghi_pkg::PLO_W;

  // captured item
  ghi_pkg::cmd_e                       cmd_q;
  logic signed [ghi_pkg::RAW_W-1:0]    raw_q;
  logic [ghi_pkg::TIME_W-1:0]          now_q;
  logic signed [ghi_pkg::SET_W-1:0]    setv_q;

  // architectural state
  logic signed [ghi_pkg::HEAD_W-1:0]   heading_q, heading_d;
  logic signed [ghi_pkg::RATE_W-1:0]   rate_q, rate_d;
  logic signed [ghi_pkg::BIAS_W-1:0]   bias_q, bias_d;
  logic                                cal_q, cal_d;
  logic [ghi_pkg::TIME_W-1:0]          last_q, last_d;
  logic signed [SUM_W-1:0]             sum_q, sum_d;
  logic [CNT_W-1:0]                    cnt_q, cnt_d;

  // work registers
  logic [DT_W-1:0]                     dt_q;
  logic signed [ghi_pkg::P_W-1:0]      p_q;
  logic [ghi_pkg::PG_W-1:0]            lo_q;
  logic signed [ghi_pkg::PG_W-1:0]     hi_q;
  logic signed [ghi_pkg::HW_W-1:0]     delta_q;
  logic signed [ghi_pkg::HW_W-1:0]     hw_q, hw_d;

  // result registers
  logic signed [ghi_pkg::HOUT_W-1:0]   hout_q;
  logic signed [ghi_pkg::RATE_W-1:0]   rout_q;
  logic signed [ghi_pkg::BIAS_W-1:0]   bout_q;
  logic                                cout_q;

  logic signed [SUM_W-1:0]             sum_nxt;
  logic [CNT_W-1:0]                    cnt_nxt;
  logic signed [NUM_W-1:0]             num;
  logic [ghi_pkg::TIME_W-1:0]          diff;
  logic [DT_W-1:0]                     dt_nxt;
  logic signed [ghi_pkg::RATE_W-1:0]   raw_sc;
  logic signed [ghi_pkg::MOP_W-1:0]    mul_a, mul_b;
  logic signed [ghi_pkg::MPROD_W-1:0]  mul_p;
  logic signed [ghi_pkg::PG_W:0]       acc_sum;
  logic signed [ghi_pkg::HW_W-1:0]     hmax_x, hmin_x, turn_x, h1, h2;

  assign sts_o.cmd        = cmd_q;
  assign sts_o.calibrated = cal_q;

  assign heading_q16_o   = hout_q;
  assign rate_q8_o       = rout_q;
  assign bias_q8_o       = bout_q;
  assign is_calibrated_o = cout_q;

  assign sum_nxt = sum_q + SUM_W'(raw_q);
  assign cnt_nxt = cnt_q + 1'b1;
  assign num     = {sum_nxt, {ghi_pkg::RFRAC_W{1'b0}}};

  assign diff   = now_q - last_q;
  assign dt_nxt = (diff > ghi_pkg::TIME_W'(MAX_DT_US)) ? DT_W'(MAX_DT_US)
                                                      : diff[DT_W-1:0];
  assign raw_sc = {raw_q[ghi_pkg::RAW_W-1], raw_q, {ghi_pkg::RFRAC_W{1'b0}}};

  assign hmax_x = ghi_pkg::HW_W'(cfg_i.hmax);
  assign hmin_x = ghi_pkg::HW_W'(cfg_i.hmin);
  assign turn_x = ghi_pkg::HW_W'(cfg_i.turn);

  // shared multiplier: rate * dt, then low and high halves of p times gain
  always_comb begin
    if (dp_cmd_i.ld_hi) begin
      mul_a = ghi_pkg::MOP_W'($signed(p_q[ghi_pkg::P_W-1:ghi_pkg::PLO_W]));
      mul_b = $signed({{(ghi_pkg::MOP_W-ghi_pkg::GAIN_W){1'b0}}, cfg_i.gain});
    end else if (dp_cmd_i.ld_lo) begin
      mul_a = $signed({{(ghi_pkg::MOP_W-ghi_pkg::PLO_W){1'b0}},
                       p_q[ghi_pkg::PLO_W-1:0]});
      mul_b = $signed({{(ghi_pkg::MOP_W-ghi_pkg::GAIN_W){1'b0}}, cfg_i.gain});
    end else begin
      mul_a = rate_q;
      mul_b = $signed({{(ghi_pkg::MOP_W-DT_W){1'b0}}, dt_q});
    end
  end

  assign mul_p   = mul_a * mul_b;
  assign acc_sum = {hi_q[ghi_pkg::PG_W-1], hi_q}
                 + {{(ghi_pkg::PG_W+1-LOH_W){1'b0}}, lo_q[ghi_pkg::PG_W-1:ghi_pkg::PLO_W]};

  assign h1 = (hw_q > hmax_x) ? hmax_x : hw_q;
  assign h2 = (h1 < hmin_x) ? hmin_x : h1;

  always_comb begin
    heading_d = heading_q;
    rate_d    = rate_q;
    bias_d    = bias_q;
    cal_d     = cal_q;
    last_d    = last_q;
    sum_d     = sum_q;
    cnt_d     = cnt_q;
    if (dp_cmd_i.cal_step) begin
      if (cnt_nxt == CNT_W'(CAL_SAMPLES)) begin
        bias_d    = ghi_pkg::BIAS_W'(num >>> CAL_LOG);
        heading_d = '0;
        rate_d    = '0;
        cal_d     = 1'b1;
        last_d    = now_q;
        sum_d     = '0;
        cnt_d     = '0;
      end else begin
        sum_d = sum_nxt;
        cnt_d = cnt_nxt;
      end
    end
    if (dp_cmd_i.rst_head) begin
      heading_d = '0;
      last_d    = now_q;
    end
    if (dp_cmd_i.set_load) begin
      last_d = now_q;
    end
    if (dp_cmd_i.upd_start) begin
      last_d = now_q;
      rate_d = raw_sc - ghi_pkg::RATE_W'(bias_q);
    end
    if (dp_cmd_i.clamp) begin
      heading_d = h2[ghi_pkg::HEAD_W-1:0];
    end
  end

  always_comb begin
    hw_d = hw_q;
    if (dp_cmd_i.set_load) begin
      hw_d = ghi_pkg::HW_W'(setv_q);
    end else if (dp_cmd_i.ld_acc) begin
      hw_d = ghi_pkg::HW_W'(heading_q) + delta_q;
    end else if (dp_cmd_i.wrap_hi) begin
      if (hw_q > hmax_x) hw_d = hw_q - turn_x;
    end else if (dp_cmd_i.wrap_lo) begin
      if (hw_q < hmin_x) hw_d = hw_q + turn_x;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heading_q <= '0;
      rate_q    <= '0;
      bias_q    <= '0;
      cal_q     <= 1'b0;
      last_q    <= '0;
      sum_q     <= '0;
      cnt_q     <= '0;
    end else begin
      heading_q <= heading_d;
      rate_q    <= rate_d;
      bias_q    <= bias_d;
      cal_q     <= cal_d;
      last_q    <= last_d;
      sum_q     <= sum_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.capture) begin
      cmd_q  <= ghi_pkg::cmd_e'(cmd_i);
      raw_q  <= raw_rate_i;
      now_q  <= now_us_i;
      setv_q <= set_value_q16_i;
    end
    if (dp_cmd_i.upd_start) dt_q <= dt_nxt;
    if (dp_cmd_i.ld_p) p_q <= mul_p[ghi_pkg::P_W-1:0];
    if (dp_cmd_i.ld_lo) lo_q <= mul_p[ghi_pkg::PG_W-1:0];
    if (dp_cmd_i.ld_hi) hi_q <= mul_p[ghi_pkg::PG_W-1:0];
    if (dp_cmd_i.ld_delta) delta_q <= ghi_pkg::HW_W'(acc_sum >>> ghi_pkg::D_SHIFT);
    hw_q <= hw_d;
    if (dp_cmd_i.out_load) begin
      hout_q <= heading_q[ghi_pkg::HOUT_W-1:0];
      rout_q <= rate_q;
      bout_q <= bias_q;
      cout_q <= cal_q;
    end
  end

endmodule

// ===== rtl/gyro_heading_integrator.sv =====
// Top level of the gyro heading integrator: registers, controller and datapath.
//
//   channel  | handshake                    | payload
//   ---------+------------------------------+---------------------------------------------
//   input    | in_valid_i / in_ready_o      | cmd_i, raw_rate_i, now_us_i, set_value_q16_i
//   output   | out_valid_o / out_ready_i    | heading_q16_o, rate_q8_o, bias_q8_o,
//            |                              | is_calibrated_o
//   config   | psel, penable, pwrite, pready| paddr, pwdata, prdata
//
// One item at a time. Calibration, reset-heading and uncalibrated update items go
// straight from decode to the output step; set-heading runs the three-step heading wrap;
// a calibrated update first makes three passes through the single shared 25x25 multiplier.
// After reset the block is ready at once; no clearing pass.
// A result waiting in the output register holds the sequencer only at its last step.
module gyro_heading_integrator #(
  parameter int CAL_SAMPLES = 256,
  parameter int MAX_DT_US   = 500000
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          cmd_i,
  input  logic signed [ghi_pkg::RAW_W-1:0]    raw_rate_i,
  input  logic [ghi_pkg::TIME_W-1:0]          now_us_i,
  input  logic signed [ghi_pkg::SET_W-1:0]    set_value_q16_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [ghi_pkg::HOUT_W-1:0]   heading_q16_o,
  output logic signed [ghi_pkg::RATE_W-1:0]   rate_q8_o,
  output logic signed [ghi_pkg::BIAS_W-1:0]   bias_q8_o,
  output logic                                is_calibrated_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ghi_pkg::ADDR_W-1:0]          paddr,
  input  logic [ghi_pkg::DATA_W-1:0]          pwdata,
  output logic [ghi_pkg::DATA_W-1:0]          prdata,
  output logic                                pready
);

  ghi_pkg::cfg_t    cfg;
  ghi_pkg::dp_cmd_t dp_cmd;
  ghi_pkg::dp_sts_t dp_sts;

  ghi_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ghi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (dp_sts),
    .dp_cmd_o    (dp_cmd)
  );

  ghi_dp #(
    .CAL_SAMPLES (CAL_SAMPLES),
    .MAX_DT_US   (MAX_DT_US)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .dp_cmd_i        (dp_cmd),
    .sts_o           (dp_sts),
    .cfg_i           (cfg),
    .cmd_i           (cmd_i),
    .raw_rate_i      (raw_rate_i),
    .now_us_i        (now_us_i),
    .set_value_q16_i (set_value_q16_i),
    .heading_q16_o   (heading_q16_o),
    .rate_q8_o       (rate_q8_o),
    .bias_q8_o       (bias_q8_o),
    .is_calibrated_o (is_calibrated_o)
  );

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for gyro_heading_integrator: random and directed samples.
module testbench;

  localparam int CAL_SAMPLES  = 256;
  localparam int MAX_DT_US    = 500000;
  localparam int LIMIT_CYCLES = 600000;

  typedef struct packed {
    ghi_pkg::cmd_e                    cmd;
    logic signed [ghi_pkg::RAW_W-1:0] raw;
    logic [ghi_pkg::TIME_W-1:0]       now;
    logic signed [ghi_pkg::SET_W-1:0] setv;
  } gyro_sample_t;

  typedef struct packed {
    logic signed [ghi_pkg::HOUT_W-1:0] heading;
    logic signed [ghi_pkg::RATE_W-1:0] rate;
    logic signed [ghi_pkg::BIAS_W-1:0] bias;
    logic                              calibrated;
  } heading_result_t;

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              in_valid_i = 1'b0;
  logic                              in_ready_o;
  logic [1:0]                        cmd_i = 2'd0;
  logic signed [ghi_pkg::RAW_W-1:0]  raw_rate_i = '0;
  logic [ghi_pkg::TIME_W-1:0]        now_us_i = '0;
  logic signed [ghi_pkg::SET_W-1:0]  set_value_q16_i = '0;
  logic                              out_valid_o;
  logic                              out_ready_i = 1'b0;
  logic signed [ghi_pkg::HOUT_W-1:0] heading_q16_o;
  logic signed [ghi_pkg::RATE_W-1:0] rate_q8_o;
  logic signed [ghi_pkg::BIAS_W-1:0] bias_q8_o;
  logic                              is_calibrated_o;
  logic                              psel = 1'b0;
  logic                              penable = 1'b0;
  logic                              pwrite = 1'b0;
  logic [ghi_pkg::ADDR_W-1:0]        paddr = '0;
  logic [ghi_pkg::DATA_W-1:0]        pwdata = '0;
  logic [ghi_pkg::DATA_W-1:0]        prdata;
  logic                              pready;

  gyro_heading_integrator #(
    .CAL_SAMPLES(CAL_SAMPLES),
    .MAX_DT_US  (MAX_DT_US)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_i),
    .raw_rate_i     (raw_rate_i),
    .now_us_i       (now_us_i),
    .set_value_q16_i(set_value_q16_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .heading_q16_o  (heading_q16_o),
    .rate_q8_o      (rate_q8_o),
    .bias_q8_o      (bias_q8_o),
    .is_calibrated_o(is_calibrated_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  gyro_sample_t    sample_queue[$];
  heading_result_t expected_headings[$];
  gyro_sample_t    held;

  logic [ghi_pkg::GAIN_W-1:0] gain_cfg = ghi_pkg::GAIN_RST;
  longint                     hmax_cfg = ghi_pkg::HMAX_RST;
  longint                     hmin_cfg = ghi_pkg::HMIN_RST;
  longint                     turn_cfg = ghi_pkg::TURN_RST;

  longint        hd_acc = 0;
  longint        rate_now = 0;
  longint        bias_now = 0;
  logic          cal_done = 1'b0;
  logic [31:0]   t_last = '0;
  longint        sum_cal = 0;
  int            n_cal = 0;

  logic [31:0] gen_now = '0;
  int          gen_cal = 0;
  int          gen_center = 0;
  int          send_idle = 0;
  int          recv_stall = 0;
  int          n_samples = 0;
  int          n_checked = 0;
  int          n_errors = 0;
  int          n_calibrations = 0;
  int          n_settings = 0;
  int          cycles = 0;

  function automatic longint fold_heading(longint h);
    if (h > hmax_cfg) h -= turn_cfg;
    if (h < hmin_cfg) h += turn_cfg;
    if (h > hmax_cfg) h = hmax_cfg;
    if (h < hmin_cfg) h = hmin_cfg;
    return h;
  endfunction

  function automatic void integrate_sample(gyro_sample_t s);
    logic [31:0]        dt;
    logic signed [71:0] r72, d72, g72, prod;
    longint             num, q;
    heading_result_t    res;
    case (s.cmd)
      ghi_pkg::CMD_CAL: begin
        sum_cal += longint'(s.raw);
        n_cal++;
        if (n_cal >= CAL_SAMPLES) begin
          num = sum_cal * 256;
          q = num / CAL_SAMPLES;
          if (num % CAL_SAMPLES != 0 && num < 0) q--;
          bias_now = q;
          hd_acc = 0;
          rate_now = 0;
          cal_done = 1'b1;
          t_last = s.now;
          sum_cal = 0;
          n_cal = 0;
          n_calibrations++;
        end
      end
      ghi_pkg::CMD_UPDATE: if (cal_done) begin
        dt = s.now - t_last;
        if (dt > 32'(MAX_DT_US)) dt = 32'(MAX_DT_US);
        t_last = s.now;
        rate_now = longint'(s.raw) * 256 - bias_now;
        r72 = 72'(rate_now);
        d72 = {40'd0, dt};
        g72 = {48'd0, gain_cfg};
        prod = r72 * d72 * g72;
        hd_acc = fold_heading(hd_acc + longint'(prod >>> 40));
      end
      ghi_pkg::CMD_RESET: begin
        hd_acc = 0;
        t_last = s.now;
      end
      default: begin
        hd_acc = fold_heading(longint'(s.setv));
        t_last = s.now;
      end
    endcase
    res.heading = ghi_pkg::HOUT_W'(hd_acc);
    res.rate = ghi_pkg::RATE_W'(rate_now);
    res.bias = ghi_pkg::BIAS_W'(bias_now);
    res.calibrated = cal_done;
    expected_headings.push_back(res);
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    if (n_errors < 30)
      $display("mismatch on %s at result %0d: got %0d, expected %0d",
               field, n_checked, got, want);
    n_errors++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        integrate_sample(held);
        n_samples++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle) begin
          held = sample_queue.pop_front();
          in_valid_i      <= 1'b1;
          cmd_i           <= held.cmd;
          raw_rate_i      <= held.raw;
          now_us_i        <= held.now;
          set_value_q16_i <= held.setv;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    heading_result_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_headings.size() == 0) begin
          report_mismatch("unexpected result", longint'(heading_q16_o), 0);
        end else begin
          want = expected_headings.pop_front();
          if (heading_q16_o !== want.heading)
            report_mismatch("heading_q16", longint'(heading_q16_o), longint'(want.heading));
          if (rate_q8_o !== want.rate)
            report_mismatch("rate_q8", longint'(rate_q8_o), longint'(want.rate));
          if (bias_q8_o !== want.bias)
            report_mismatch("bias_q8", longint'(bias_q8_o), longint'(want.bias));
          if (is_calibrated_o !== want.calibrated)
            report_mismatch("is_calibrated", longint'(is_calibrated_o),
                            longint'(want.calibrated));
        end
        n_checked++;
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, expected_headings.size());
      $display("gyro_heading_integrator verification failed");
      $finish;
    end
  end

  function automatic logic signed [ghi_pkg::RAW_W-1:0] near_raw(int center, int spread);
    int v;
    v = center + int'($urandom_range(2 * spread)) - spread;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return ghi_pkg::RAW_W'(v);
  endfunction

  function automatic logic signed [ghi_pkg::SET_W-1:0] rand_setv();
    return ghi_pkg::SET_W'(int'($urandom_range(70778880)) - 35389440);
  endfunction

  function automatic logic [31:0] pick_dt();
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom_range(20000);
      4, 5:       return $urandom_range(700000);
      6:          return MAX_DT_US - 1 + $urandom_range(2);
      7:          return $urandom;
      8:          return $urandom_range(3);
      default:    return $urandom_range(500000, 400000);
    endcase
  endfunction

  function automatic void push_sample(ghi_pkg::cmd_e c,
                                      logic signed [ghi_pkg::RAW_W-1:0] r,
                                      logic signed [ghi_pkg::SET_W-1:0] sv,
                                      logic [31:0] dt);
    gyro_sample_t s;
    gen_now += dt;
    s.cmd = c;
    s.raw = r;
    s.now = gen_now;
    s.setv = sv;
    sample_queue.push_back(s);
    if (c == ghi_pkg::CMD_CAL) gen_cal = (gen_cal + 1) % CAL_SAMPLES;
  endfunction

  function automatic void cal_burst(int center, int spread);
    gen_center = center;
    push_sample(ghi_pkg::CMD_CAL, near_raw(center, spread), rand_setv(), pick_dt());
    while (gen_cal != 0)
      push_sample(ghi_pkg::CMD_CAL, near_raw(center, spread), rand_setv(), pick_dt());
  endfunction

  function automatic void random_samples(int n);
    int                               k;
    logic signed [ghi_pkg::RAW_W-1:0] r;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      r = $urandom_range(1) ? near_raw(gen_center, 300) : ghi_pkg::RAW_W'($urandom);
      if (k < 66) push_sample(ghi_pkg::CMD_UPDATE, r, rand_setv(), pick_dt());
      else if (k < 78) push_sample(ghi_pkg::CMD_CAL, r, rand_setv(), pick_dt());
      else if (k < 88) push_sample(ghi_pkg::CMD_RESET, r, rand_setv(), pick_dt());
      else push_sample(ghi_pkg::CMD_SET, r, rand_setv(), pick_dt());
    end
  endfunction

  task automatic write_reg(ghi_pkg::reg_e idx, logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      ghi_pkg::REG_GAIN: gain_cfg = val[ghi_pkg::GAIN_W-1:0];
      ghi_pkg::REG_HMAX: hmax_cfg = longint'(val[ghi_pkg::MAX_W-1:0]);
      ghi_pkg::REG_HMIN: hmin_cfg = longint'($signed(val[ghi_pkg::MIN_W-1:0]));
      default:           turn_cfg = longint'(val[ghi_pkg::TURN_W-1:0]);
    endcase
  endtask

  task automatic apply_cfg(logic [ghi_pkg::GAIN_W-1:0] g, logic [ghi_pkg::MAX_W-1:0] hmx,
                           int hmn, logic [ghi_pkg::TURN_W-1:0] tn);
    write_reg(ghi_pkg::REG_GAIN, 32'(g));
    write_reg(ghi_pkg::REG_HMAX, 32'(hmx));
    write_reg(ghi_pkg::REG_HMIN, 32'(hmn));
    write_reg(ghi_pkg::REG_TURN, 32'(tn));
    n_settings++;
  endtask

  task automatic drain();
    while (sample_queue.size() != 0 || in_valid_i || expected_headings.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    gen_now = $urandom;
    for (int p = 0; p < 6; p++) begin
      send_idle  = (p % 4 == 1) ? 77 : (p % 4 == 3) ? 32 : 0;
      recv_stall = (p % 4 == 2) ? 77 : (p % 4 == 3) ? 32 : 0;
      case (p)
        0: begin
          apply_cfg(ghi_pkg::GAIN_RST, ghi_pkg::HMAX_RST, int'(ghi_pkg::HMIN_RST),
                    ghi_pkg::TURN_RST);
          push_sample(ghi_pkg::CMD_UPDATE, 32767, 0, 1000);
          push_sample(ghi_pkg::CMD_UPDATE, -32768, 0, 0);
          push_sample(ghi_pkg::CMD_SET, 0, 35389440, 10);
          push_sample(ghi_pkg::CMD_SET, 0, -35389440, 10);
          push_sample(ghi_pkg::CMD_SET, 0, 11796481, 10);
          push_sample(ghi_pkg::CMD_SET, 0, -11796481, 10);
          push_sample(ghi_pkg::CMD_SET, 0, 11796480, 10);
          push_sample(ghi_pkg::CMD_SET, 0, -11796480, 10);
          push_sample(ghi_pkg::CMD_RESET, -1, -1, 10);
          push_sample(ghi_pkg::CMD_CAL, 32767, 0, 1);
          push_sample(ghi_pkg::CMD_CAL, -32768, 0, 1);
          push_sample(ghi_pkg::CMD_UPDATE, 12345, 0, 100);
          cal_burst(int'($urandom_range(65535)) - 32768, 64);
          push_sample(ghi_pkg::CMD_UPDATE, 32767, 0, 0);
          push_sample(ghi_pkg::CMD_UPDATE, -32768, 0, MAX_DT_US);
          push_sample(ghi_pkg::CMD_UPDATE, 32767, 0, MAX_DT_US + 1);
          push_sample(ghi_pkg::CMD_UPDATE, near_raw(gen_center, 50), 0,
                      32'd0 - gen_now - 32'd100);
          push_sample(ghi_pkg::CMD_UPDATE, near_raw(gen_center, 50), 0, 300);
          push_sample(ghi_pkg::CMD_SET, 0, 35389440, 5);
          push_sample(ghi_pkg::CMD_UPDATE, -32768, 0, 32'hFFFF_FFFF);
        end
        1: apply_cfg(24'hFF_FFFF, 23592960, -23592960, 47185920);
        2: apply_cfg(1, 0, 0, 1);
        3: begin
          apply_cfg(ghi_pkg::GAIN_W'($urandom_range(16777215, 1)),
                    ghi_pkg::MAX_W'($urandom_range(23592960)),
                    -int'($urandom_range(23592960)),
                    ghi_pkg::TURN_W'($urandom_range(47185920, 1)));
          cal_burst(-32768, 0);
        end
        4: apply_cfg(1500000, 5898240, -655360, 6553600);
        default: begin
          apply_cfg(ghi_pkg::GAIN_W'($urandom_range(16777215, 1)),
                    ghi_pkg::MAX_W'($urandom_range(23592960)),
                    -int'($urandom_range(23592960)),
                    ghi_pkg::TURN_W'($urandom_range(47185920, 1)));
          cal_burst(32767, 0);
        end
      endcase
      random_samples(140);
      drain();
    end
    repeat (20) @(posedge clk_i);
    $display("%0d samples driven, %0d results checked, %0d calibration runs, %0d settings",
             n_samples, n_checked, n_calibrations, n_settings);
    $display("idling covered: none, sender 77%%, receiver 77%%, both 32%%");
    if (n_errors == 0) begin
      $display("gyro_heading_integrator verification clean");
    end else begin
      $display("gyro_heading_integrator verification failed");
    end
    $finish;
  end

endmodule
